### rtl/trw_pkg.sv
// Package for the trapped rainwater total block.
// Holds sizing constants, the controller state type and the command/status structs.
// No dependencies.
package trw_pkg;

   // Store depth and bar height width
   localparam int MAX_BARS    = 128;
   localparam int HEIGHT_BITS = 16;

   // Derived widths
   localparam int ADDR_BITS  = $clog2(MAX_BARS);
   localparam int COUNT_BITS = $clog2(MAX_BARS + 1);
   localparam int TOTAL_BITS = 23;
   localparam int SUM_BITS   = ((TOTAL_BITS > HEIGHT_BITS) ? TOTAL_BITS : HEIGHT_BITS) + 1;

   // Saturation limit of the total
   localparam logic [TOTAL_BITS-1:0] TOTAL_LIMIT = '1;

   // Controller states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_BACK,
      ST_BACK_DRAIN,
      ST_FWD,
      ST_FWD_DRAIN,
      ST_SUM_DRAIN,
      ST_RESULT
   } trw_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;         // store one bar
      logic load_last;    // bar closes the run, arm the walks
      logic back_issue;   // read one bar of the backward walk
      logic fwd_issue;    // read one bar of the forward walk
      logic clear_count;  // run is consumed, restart the fill count
   } trw_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic idx_zero;     // walk index at the first bar
      logic idx_last;     // walk index at the last stored bar
   } trw_status_type;

endpackage

### rtl/trw_ctrl.sv
// Controller for the trapped rainwater total block.
// Sequences loading, backward walk, forward walk and result hand-off.
// Depends on trw_pkg.
module trw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  trw_pkg::trw_status_type status,
   output trw_pkg::trw_cmd_type    cmd
);
   import trw_pkg::*;

   trw_state_type state_ff;
   trw_state_type state_in;
   logic          req_accept;

   // Accept bars while loading, or while a result waits unless the bar ends a run
   assign req_stall  = !((state_ff == ST_LOAD) || ((state_ff == ST_RESULT) && !req_last));
   assign req_accept = req_valid && !req_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept && req_last) state_in = ST_BACK;
         end
         ST_BACK: begin
            if (status.idx_zero) state_in = ST_BACK_DRAIN;
         end
         ST_BACK_DRAIN: state_in = ST_FWD;
         ST_FWD: begin
            if (status.idx_last) state_in = ST_FWD_DRAIN;
         end
         ST_FWD_DRAIN:  state_in = ST_SUM_DRAIN;
         ST_SUM_DRAIN:  state_in = ST_RESULT;
         ST_RESULT: begin
            if (!rsp_stall) state_in = ST_LOAD;
         end
         default:       state_in = ST_LOAD;
      endcase
   end

   // Outputs
   always_comb begin
      cmd             = '0;
      cmd.load        = req_accept;
      cmd.load_last   = req_accept && req_last;
      cmd.back_issue  = (state_ff == ST_BACK);
      cmd.fwd_issue   = (state_ff == ST_FWD);
      cmd.clear_count = (state_ff == ST_FWD_DRAIN);
      rsp_valid       = (state_ff == ST_RESULT);
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/trw_datapath.sv
// Datapath for the trapped rainwater total block.
// Bar and right-maximum stores, walk index, running maxima and the saturating total.
// Depends on trw_pkg.
module trw_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  trw_pkg::trw_cmd_type                cmd,
   output trw_pkg::trw_status_type             status,
   input  logic [15:0]                         req_height,
   output logic [trw_pkg::TOTAL_BITS-1:0]      rsp_total_water
);
   import trw_pkg::*;

   logic [HEIGHT_BITS-1:0] height_mem [MAX_BARS];
   logic [HEIGHT_BITS-1:0] rmax_mem   [MAX_BARS];

   logic [COUNT_BITS-1:0]  count_ff;
   logic [ADDR_BITS-1:0]   idx_ff;
   logic [ADDR_BITS-1:0]   idx_in;
   logic                   count_room;

   logic [HEIGHT_BITS-1:0] height_rd_ff;
   logic [HEIGHT_BITS-1:0] rmax_rd_ff;
   logic                   back_vld_ff;
   logic [ADDR_BITS-1:0]   back_addr_ff;
   logic                   fwd_vld_ff;

   logic [HEIGHT_BITS-1:0] run_ff;
   logic [HEIGHT_BITS-1:0] run_in;
   logic [HEIGHT_BITS-1:0] left_ff;
   logic [HEIGHT_BITS-1:0] left_in;
   logic [HEIGHT_BITS-1:0] water_level;
   logic [HEIGHT_BITS-1:0] diff_ff;
   logic                   diff_vld_ff;
   logic [SUM_BITS-1:0]    sum_wide;
   logic [TOTAL_BITS-1:0]  sum_ff;
   logic [TOTAL_BITS-1:0]  sum_in;

   assign count_room = (count_ff < COUNT_BITS'(MAX_BARS));

   // Walk status
   assign status.idx_zero = (idx_ff == '0);
   assign status.idx_last = (COUNT_BITS'(idx_ff) == (count_ff - COUNT_BITS'(1)));

   // Store bars; drop those past the store depth
   always_ff @(posedge clock) begin
      if (cmd.load && count_room) begin
         height_mem[count_ff[ADDR_BITS-1:0]] <= req_height[HEIGHT_BITS-1:0];
      end
   end

   // Registered reads at the walk index
   always_ff @(posedge clock) begin
      height_rd_ff <= height_mem[idx_ff];
      rmax_rd_ff   <= rmax_mem[idx_ff];
   end

   // Write right maxima from the backward walk
   always_ff @(posedge clock) begin
      if (back_vld_ff) begin
         rmax_mem[back_addr_ff] <= run_in;
      end
   end

   // Walk index: arm at the last bar, step down backward, step up forward
   always_comb begin
      idx_in = idx_ff;
      priority if (cmd.load_last) begin
         idx_in = count_room ? count_ff[ADDR_BITS-1:0] : ADDR_BITS'(MAX_BARS - 1);
      end else if (cmd.back_issue && !status.idx_zero) begin
         idx_in = idx_ff - ADDR_BITS'(1);
      end else if (cmd.fwd_issue && !status.idx_last) begin
         idx_in = idx_ff + ADDR_BITS'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   // Running maxima and water over one bar
   assign run_in      = (height_rd_ff > run_ff) ? height_rd_ff : run_ff;
   assign left_in     = (height_rd_ff > left_ff) ? height_rd_ff : left_ff;
   assign water_level = (left_in < rmax_rd_ff) ? left_in : rmax_rd_ff;

   // Saturating accumulate
   assign sum_wide = SUM_BITS'(sum_ff) + SUM_BITS'(diff_ff);
   assign sum_in   = (sum_wide > SUM_BITS'(TOTAL_LIMIT)) ? TOTAL_LIMIT
                                                         : sum_wide[TOTAL_BITS-1:0];

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         idx_ff      <= '0;
         back_vld_ff <= 1'b0;
         fwd_vld_ff  <= 1'b0;
         diff_vld_ff <= 1'b0;
      end else begin
         if (cmd.clear_count) begin
            count_ff <= '0;
         end else if (cmd.load && count_room) begin
            count_ff <= count_ff + COUNT_BITS'(1);
         end
         idx_ff      <= idx_in;
         back_vld_ff <= cmd.back_issue;
         fwd_vld_ff  <= cmd.fwd_issue;
         diff_vld_ff <= fwd_vld_ff;
      end
   end

   // Walk registers; clear the running values when a run closes
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= '0;
         left_ff <= '0;
         sum_ff  <= '0;
      end else if (cmd.load_last) begin
         run_ff  <= '0;
         left_ff <= '0;
         sum_ff  <= '0;
      end else begin
         if (back_vld_ff) run_ff  <= run_in;
         if (fwd_vld_ff)  left_ff <= left_in;
         if (diff_vld_ff) sum_ff  <= sum_in;
      end
   end

   // Hold the read address and per-bar water
   always_ff @(posedge clock) begin
      back_addr_ff <= idx_ff;
      diff_ff      <= water_level - height_rd_ff;
   end

   assign rsp_total_water = sum_ff;

   // Fill count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(MAX_BARS))
      else $error("fill count past store depth");

   // Backward and forward walks never overlap in the read pipeline
   a_walk_excl: assert property (@(posedge clock) disable iff (reset)
      !(back_vld_ff && fwd_vld_ff))
      else $error("backward and forward reads overlap");

   // Forward reads stay inside the stored run
   a_fwd_in_run: assert property (@(posedge clock) disable iff (reset)
      cmd.fwd_issue |-> (COUNT_BITS'(idx_ff) < count_ff))
      else $error("forward read past stored bars");

   // Backward walk ends at the first bar before the forward walk starts
   a_back_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.back_issue && status.idx_zero) |=> (idx_ff == '0))
      else $error("walk index moved after backward walk");

endmodule

### rtl/trapped_rainwater_total_top.sv
// Channel   Direction  Ports                                  Transaction
// req       in         req_valid, req_stall, req_height,      one bar height, last flag
//                      req_last
// rsp       out        rsp_valid, rsp_stall, rsp_total_water  total water of one run
//
// A run of n stored bars is loaded, walked backward to build the right maxima and then
// walked forward to sum the water before the total shows; the single read port of each
// bar store sets one bar per walk cycle.
// Reset is synchronous and active high; the stores need no clearing.
// While a total waits on rsp_stall, bars that do not close a run are still taken.
// Top level of the trapped rainwater total block.
// Depends on trw_pkg, trw_ctrl and trw_datapath.
module trapped_rainwater_total_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [15:0]                    req_height,
   input  logic                           req_last,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [trw_pkg::TOTAL_BITS-1:0] rsp_total_water
);
   import trw_pkg::*;

   trw_cmd_type    cmd;
   trw_status_type status;

   // Sequence the run
   trw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Store and walk the bars
   trw_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_height      (req_height),
      .rsp_total_water (rsp_total_water)
   );

endmodule
